// ===== hw/rtl/disk_request_scheduler_unit_macros.svh =====
// Assertion macros for the disk request scheduler.
`ifndef DISK_REQUEST_SCHEDULER_UNIT_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DRS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DRS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DRS_ASSERT_IMPL(label, clk, rst_n, prop)
`define DRS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hw/rtl/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Types, constants and control codes shared by the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package drs_pkg;
    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [8:0]  MAX_WRITE_LEN = 9'd256;
    localparam logic [10:0] MAX_CYLINDERS = 11'd1024;
    localparam logic [16:0] MAX_SECTORS   = 17'd65536;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_CYL    = 3'd2;
    localparam logic [2:0] REG_SEC    = 3'd3;
    localparam logic [2:0] REG_DELAY  = 3'd4;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SSTF = 2'd1;

    typedef struct packed {
        logic        operation;
        logic [15:0] cylinder;
        logic [16:0] sector;
        logic        is_write;
        logic [8:0]  write_length;
    } in_word_t;

    typedef struct packed {
        logic [15:0] request_number;
        logic [15:0] served_cylinder;
        logic [16:0] served_sector;
        logic        served_write;
        logic        accepted;
        logic [9:0]  seek_distance;
        logic [31:0] total_delay;
        logic        is_summary;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_STORE, ST_SCAN, ST_EVAL, ST_MUL, ST_EMIT, ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic store;       // write input word into free slot
        logic scan_start;  // clear scan trackers
        logic scan_step;   // examine one slot
        logic eval;        // read chosen entry, compute range check
        logic mul;         // delay times seek distance product
        logic emit;        // load output register with dispatch word, update head
        logic summary;     // load output register with summary word
        logic last_flag;
    } cmd_t;

    typedef struct packed {
        logic need_dispatch;
        logic scan_done;
        logic found;
    } status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/disk_request_scheduler_unit.sv =====
// A submit that dispatches stores its word, runs a 32-slot scan, then evaluates,
// multiplies and emits; the next word is taken after the emit. A submit that
// only queues stores its word and returns to idle. A flush of n pending requests
// runs scan, evaluate, multiply and emit per request, then a final empty scan and
// the summary. Reset (asynchronous, active low) empties the queue, zeroes head,
// total and numbering, and loads the register defaults.
// ----------------------------------------------------------------------------
// disk_request_scheduler_unit
// Disk request queue with FCFS, SSTF and C-LOOK dispatch.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_request_scheduler_unit_macros.svh"
module disk_request_scheduler_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [16:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire drs_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output drs_pkg::out_word_t      out_data
);
    drs_pkg::cmd_t    cmd;
    drs_pkg::status_t status;

    drs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_op    (in_data.operation),
        .out_busy (out_valid && !out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    drs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    `DRS_ASSERT_IMPL(a_no_double_load, clk, rst_n, !(cmd.emit && cmd.summary))
    `DRS_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.emit || cmd.summary, out_valid)
    `DRS_ASSERT_IMPL(a_summary_last, clk, rst_n, !(out_valid && out_data.is_summary) || out_data.last)
endmodule
`default_nettype wire

// ===== hw/rtl/drs_ctrl.sv =====
// ----------------------------------------------------------------------------
// drs_ctrl
// Sequencer: store, scan, evaluate, multiply, emit, with flush drain loop and summary.
// ----------------------------------------------------------------------------
`default_nettype none
module drs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_op,
    input  wire logic             out_busy,
    input  wire drs_pkg::status_t status,
    output drs_pkg::cmd_t         cmd
);
    drs_pkg::state_t state_reg, state_next;
    logic flush_reg, flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drs_pkg::ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            drs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    flush_next = in_op;
                    if (in_op)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = drs_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        state_next = drs_pkg::ST_STORE;
                    end
                end
            end
            drs_pkg::ST_STORE:
            begin
                cmd.scan_start = 1'b1;
                state_next = status.need_dispatch ? drs_pkg::ST_SCAN : drs_pkg::ST_IDLE;
            end
            drs_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = drs_pkg::ST_EVAL;
            end
            drs_pkg::ST_EVAL:
            begin
                if (status.found)
                begin
                    cmd.eval = 1'b1;
                    state_next = drs_pkg::ST_MUL;
                end
                else
                    state_next = drs_pkg::ST_SUMMARY;
            end
            drs_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = drs_pkg::ST_EMIT;
            end
            drs_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.last_flag = !flush_reg;
                    cmd.scan_start = 1'b1;
                    state_next = flush_reg ? drs_pkg::ST_SCAN : drs_pkg::ST_IDLE;
                end
            end
            drs_pkg::ST_SUMMARY:
            begin
                if (!out_busy)
                begin
                    cmd.summary = 1'b1;
                    cmd.last_flag = 1'b1;
                    state_next = drs_pkg::ST_IDLE;
                end
            end
            default: state_next = drs_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/drs_datapath.sv =====
// ----------------------------------------------------------------------------
// drs_datapath
// Request queue storage, serial selection scan, seek and delay arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module drs_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [16:0]       cfg_data,
    input  wire drs_pkg::in_word_t in_word,
    input  wire drs_pkg::cmd_t     cmd,
    output drs_pkg::status_t       status,
    output drs_pkg::out_word_t     out_word,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    localparam int DW = drs_pkg::QUEUE_DEPTH;
    localparam int IW = drs_pkg::IDX_W;
    localparam int CW = drs_pkg::CNT_W;

    // configuration
    logic [1:0]  mode_reg;
    logic [5:0]  limit_reg;
    logic [10:0] cyl_cnt_reg;
    logic [16:0] sec_cnt_reg;
    logic [15:0] delay_reg;

    // queue memories (entry fields)
    logic [15:0] mem_cyl [DW];
    logic [16:0] mem_sec [DW];
    logic [9:0]  mem_info [DW];
    logic [15:0] mem_num [DW];
    logic [IW-1:0] age_reg [DW];
    logic [DW-1:0] valid_reg;

    logic [CW-1:0] count_reg;
    logic [9:0]    head_reg;
    logic [31:0]   total_reg;
    logic [15:0]   number_reg;

    // scan state
    logic [CW-1:0] scan_reg;
    logic          best_ok_reg;
    logic          best_up_reg;
    logic [IW-1:0] best_reg;
    logic [15:0]   best_cyl_reg;
    logic [15:0]   best_dist_reg;
    logic [IW-1:0] best_age_reg;

    // chosen entry
    logic [15:0] sel_cyl_reg;
    logic [16:0] sel_sec_reg;
    logic        sel_wr_reg;
    logic [15:0] sel_num_reg;
    logic        sel_ok_reg;
    logic [9:0]  sel_dist_reg;
    logic [31:0] prod_reg;
    logic        out_valid_reg;
    drs_pkg::out_word_t out_reg;

    logic [IW-1:0] free_slot;
    logic [CW-1:0] limit_eff;
    logic [IW-1:0] scan_idx;
    logic [15:0]   c_cyl;
    logic [15:0]   c_dist;
    logic          c_up;
    logic          take;
    logic [10:0]   cc_eff;
    logic [16:0]   sc_eff;
    logic [9:0]    e_info;
    logic [32:0]   sum;

    assign scan_idx = scan_reg[IW-1:0];
    assign c_cyl    = mem_cyl[scan_idx];
    assign c_up     = c_cyl >= {6'd0, head_reg};
    // full 16-bit distance: out-of-range cylinders still compete in SSTF
    assign c_dist   = c_up ? (c_cyl - {6'd0, head_reg})
                           : ({6'd0, head_reg} - c_cyl);

    always_comb
    begin
        free_slot = '0;
        for (int i = DW - 1; i >= 0; i--)
            if (!valid_reg[i])
                free_slot = IW'(i);
    end

    always_comb
    begin
        if (limit_reg == 6'd0)
            limit_eff = CW'(1);
        else if (32'(limit_reg) > DW)
            limit_eff = CW'(DW);
        else
            limit_eff = CW'(limit_reg);
    end

    always_comb
    begin
        take = 1'b0;
        if (valid_reg[scan_idx])
        begin
            if (!best_ok_reg)
                take = 1'b1;
            else
            begin
                unique case (mode_reg)
                    drs_pkg::MODE_FCFS: take = age_reg[scan_idx] < best_age_reg;
                    drs_pkg::MODE_SSTF:
                        take = c_dist < best_dist_reg ||
                               (c_dist == best_dist_reg && age_reg[scan_idx] > best_age_reg);
                    default:
                        if (c_up != best_up_reg)
                            take = c_up;
                        else
                            take = c_cyl < best_cyl_reg ||
                                   (c_cyl == best_cyl_reg &&
                                    age_reg[scan_idx] < best_age_reg);
                endcase
            end
        end
    end

    assign cc_eff = cyl_cnt_reg > drs_pkg::MAX_CYLINDERS ? drs_pkg::MAX_CYLINDERS : cyl_cnt_reg;
    assign sc_eff = sec_cnt_reg > drs_pkg::MAX_SECTORS ? drs_pkg::MAX_SECTORS : sec_cnt_reg;
    assign e_info = mem_info[best_reg];
    assign sum    = {1'b0, total_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem_cyl[free_slot]  <= in_word.cylinder;
            mem_sec[free_slot]  <= in_word.sector;
            mem_info[free_slot] <= {in_word.is_write, in_word.write_length};
            mem_num[free_slot]  <= number_reg;
        end
        if (cmd.eval)
        begin
            sel_cyl_reg  <= mem_cyl[best_reg];
            sel_sec_reg  <= mem_sec[best_reg];
            sel_wr_reg   <= e_info[9];
            sel_num_reg  <= mem_num[best_reg];
            sel_ok_reg   <= {5'd0, mem_cyl[best_reg]} < {10'd0, cc_eff}
                            && mem_sec[best_reg] < sc_eff
                            && !(e_info[9] && e_info[8:0] > drs_pkg::MAX_WRITE_LEN);
            sel_dist_reg <= best_dist_reg[9:0];
        end
        if (cmd.mul)
            prod_reg <= 32'(delay_reg) * 32'(sel_dist_reg);
        if (cmd.emit)
        begin
            out_reg.request_number  <= sel_num_reg;
            out_reg.served_cylinder <= sel_cyl_reg;
            out_reg.served_sector   <= sel_sec_reg;
            out_reg.served_write    <= sel_wr_reg;
            out_reg.accepted        <= sel_ok_reg;
            out_reg.seek_distance   <= sel_ok_reg ? sel_dist_reg : 10'd0;
            out_reg.total_delay     <= !sel_ok_reg ? total_reg
                                     : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
            out_reg.is_summary      <= 1'b0;
            out_reg.last            <= cmd.last_flag;
        end
        else if (cmd.summary)
        begin
            out_reg.request_number  <= number_reg;
            out_reg.served_cylinder <= '0;
            out_reg.served_sector   <= '0;
            out_reg.served_write    <= 1'b0;
            out_reg.accepted        <= 1'b1;
            out_reg.seek_distance   <= '0;
            out_reg.total_delay     <= total_reg;
            out_reg.is_summary      <= 1'b1;
            out_reg.last            <= 1'b1;
        end
        if (cmd.scan_step && take)
        begin
            best_reg      <= scan_idx;
            best_cyl_reg  <= c_cyl;
            best_dist_reg <= c_dist;
            best_age_reg  <= age_reg[scan_idx];
            best_up_reg   <= c_up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            limit_reg     <= 6'd32;
            cyl_cnt_reg   <= 11'd1024;
            sec_cnt_reg   <= 17'd65536;
            delay_reg     <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            total_reg     <= '0;
            number_reg    <= '0;
            scan_reg      <= '0;
            best_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DW; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    drs_pkg::REG_POLICY: mode_reg    <= cfg_data[1:0];
                    drs_pkg::REG_LIMIT:  limit_reg   <= cfg_data[5:0];
                    drs_pkg::REG_CYL:    cyl_cnt_reg <= cfg_data[10:0];
                    drs_pkg::REG_SEC:    sec_cnt_reg <= cfg_data[16:0];
                    drs_pkg::REG_DELAY:  delay_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.emit || cmd.summary)
                out_valid_reg <= 1'b1;
            if (cmd.store)
            begin
                valid_reg[free_slot] <= 1'b1;
                age_reg[free_slot]   <= count_reg[IW-1:0];
                count_reg            <= count_reg + CW'(1);
                number_reg           <= number_reg + 16'd1;
            end
            if (cmd.scan_start)
            begin
                scan_reg    <= '0;
                best_ok_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + CW'(1);
                if (take)
                    best_ok_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                for (int i = 0; i < DW; i++)
                    if (valid_reg[i] && age_reg[i] > best_age_reg)
                        age_reg[i] <= age_reg[i] - IW'(1);
                valid_reg[best_reg] <= 1'b0;
                if (count_reg != '0)
                    count_reg <= count_reg - CW'(1);
                if (sel_ok_reg)
                begin
                    total_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    head_reg  <= sel_cyl_reg[9:0];
                end
            end
            if (cmd.summary)
            begin
                number_reg <= number_reg + 16'd1;
                total_reg  <= '0;
                count_reg  <= '0;
            end
        end
    end

    assign status.need_dispatch = count_reg >= limit_eff;
    assign status.scan_done     = scan_reg == CW'(DW - 1);
    assign status.found         = best_ok_reg;
    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire
